/* src/ffra_pkg.sv */
// Shared codes, widths and types for the first-fit region allocator.
`default_nettype none
package ffra_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_ADDR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 1'b1;

  localparam logic [31:0] LAST_ADDR_RESET = 32'hFFFF_FFFF;
  localparam logic [31:0] BASE_RESET      = 32'h0100_0000;

  localparam int USED_W = 33;
  localparam logic [USED_W-1:0] USED_RESET = 33'h0_0100_0000;

  // allocation granule, a power of two
  localparam int PAGE_BYTES = 4096;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;
  localparam logic [1:0] CMD_RSVD    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_NO_SLOT   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage
`default_nettype wire

/* src/ffra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/ffra_round.sv */
// Page round-up of a requested length, registered.
`default_nettype none
module ffra_round (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] req_length,
  output logic        done,
  output logic [32:0] len
);
  import ffra_pkg::*;

  localparam logic [32:0] PAGE_M1 = 33'(PAGE_BYTES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      len  <= '0;
    end else begin
      done <= start;
      if (start) begin
        // add page minus one, then drop the low bits
        len <= ({1'b0, req_length} + PAGE_M1) & ~PAGE_M1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/ffra_scan.sv */
// Sequential search for the lowest clear bit of a slot-valid vector.
`default_nettype none
module ffra_scan #(
  parameter int N = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [N-1:0]         vec,
  output ffra_pkg::scan_stat_t stat,
  output logic [$clog2(N)-1:0] idx
);
  import ffra_pkg::*;

  localparam int IW = $clog2(N);
  localparam logic [IW-1:0] LAST = IW'(N - 1);

  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        priority if (!vec[idx]) begin
          busy       <= 1'b0;
          stat.done  <= 1'b1;
          stat.found <= 1'b1;
        end else if (idx == LAST) begin
          busy       <= 1'b0;
          stat.done  <= 1'b1;
          stat.found <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* src/first_fit_region_allocator_core.sv */
// Top level: sequencer, descriptor tables and counters of the region allocator.
//
//  channel | direction | handshake            | word
//  cfg     | in        | cfg_wr_en            | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall  | cmd, min_start, req_length, block_address
//  out     | out       | out_valid / out_stall| status, granted_address, block_size, used_total
//
// One command at a time. Allocate: rounding, a walk of the free extents, the grant
// slot search, then writing and linking the grant. Release and query: a walk of the
// grants; release adds the free slot search, then a walk of the free extents to
// merge with, or an append. Every command ends by loading the result. Reset and
// every config write start a table init; in_stall is high. A finished result
// waits in the output register while out_stall is high.
`default_nettype none
module first_fit_region_allocator_core #(
  parameter int FREE_SLOTS  = 64,
  parameter int GRANT_SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ffra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd,
  input  logic [31:0]                    min_start,
  input  logic [31:0]                    req_length,
  input  logic [31:0]                    block_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [31:0]                    granted_address,
  output logic [31:0]                    block_size,
  output logic [ffra_pkg::USED_W-1:0]    used_total
);
  import ffra_pkg::*;

  localparam int FIW = $clog2(FREE_SLOTS);
  localparam int FLW = $clog2(FREE_SLOTS + 1);
  localparam int GIW = $clog2(GRANT_SLOTS);
  localparam int GLW = $clog2(GRANT_SLOTS + 1);
  localparam logic [FLW-1:0] FNIL = FLW'(FREE_SLOTS);
  localparam logic [GLW-1:0] GNIL = GLW'(GRANT_SLOTS);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ROUND, S_AW_RD, S_AW_CMP, S_AG_SCAN, S_GNEW, S_GLINK,
    S_GW_RD, S_GW_CMP, S_RF_SCAN, S_RW_RD, S_RW_CMP, S_RAPP, S_FLINK, S_FINISH
  } state_t;

  state_t state;

  logic [31:0] cfg_last;
  logic [31:0] cfg_base;
  logic [FREE_SLOTS-1:0]  free_valid;
  logic [GRANT_SLOTS-1:0] grant_valid;
  logic [FLW-1:0] fhead, ftail;
  logic [GLW-1:0] ghead, gtail;
  logic [USED_W-1:0] used;

  // item and walk registers
  logic [1:0]  cmd_r;
  logic [31:0] m_r, addr_r;
  logic [32:0] len_r;
  logic [FLW-1:0] fp, e_prev, e_next, f_slot, old_ftail;
  logic [GLW-1:0] gp, g_prev, g_next, g_slot, old_gtail;
  logic [31:0] e_s, e_len, gs_r, gl_r;
  logic        top_r;
  logic [1:0]  r_status;
  logic [31:0] r_addr, r_size;

  // free table RAMs
  logic f_we_s, f_we_l, f_we_p, f_we_n;
  logic [FIW-1:0] f_wa_s, f_wa_l, f_wa_p, f_wa_n;
  logic [31:0] f_wd_s, f_wd_l;
  logic [FLW-1:0] f_wd_p, f_wd_n;
  logic [31:0] fs_q, fl_q;
  logic [FLW-1:0] fprev_q, fnext_q;

  // grant table RAMs
  logic g_we_s, g_we_l, g_we_p, g_we_n;
  logic [GIW-1:0] g_wa_s, g_wa_l, g_wa_p, g_wa_n;
  logic [31:0] g_wd_s, g_wd_l;
  logic [GLW-1:0] g_wd_p, g_wd_n;
  logic [31:0] gs_q, gl_q;
  logic [GLW-1:0] gprev_q, gnext_q;

  ffra_ram #(.WIDTH(32), .DEPTH(FREE_SLOTS)) u_fstart (.clk, .we(f_we_s),
    .waddr(f_wa_s), .wdata(f_wd_s), .raddr(fp[FIW-1:0]), .rdata(fs_q));
  ffra_ram #(.WIDTH(32), .DEPTH(FREE_SLOTS)) u_flen (.clk, .we(f_we_l),
    .waddr(f_wa_l), .wdata(f_wd_l), .raddr(fp[FIW-1:0]), .rdata(fl_q));
  ffra_ram #(.WIDTH(FLW), .DEPTH(FREE_SLOTS)) u_fprev (.clk, .we(f_we_p),
    .waddr(f_wa_p), .wdata(f_wd_p), .raddr(fp[FIW-1:0]), .rdata(fprev_q));
  ffra_ram #(.WIDTH(FLW), .DEPTH(FREE_SLOTS)) u_fnext (.clk, .we(f_we_n),
    .waddr(f_wa_n), .wdata(f_wd_n), .raddr(fp[FIW-1:0]), .rdata(fnext_q));
  ffra_ram #(.WIDTH(32), .DEPTH(GRANT_SLOTS)) u_gstart (.clk, .we(g_we_s),
    .waddr(g_wa_s), .wdata(g_wd_s), .raddr(gp[GIW-1:0]), .rdata(gs_q));
  ffra_ram #(.WIDTH(32), .DEPTH(GRANT_SLOTS)) u_glen (.clk, .we(g_we_l),
    .waddr(g_wa_l), .wdata(g_wd_l), .raddr(gp[GIW-1:0]), .rdata(gl_q));
  ffra_ram #(.WIDTH(GLW), .DEPTH(GRANT_SLOTS)) u_gprev (.clk, .we(g_we_p),
    .waddr(g_wa_p), .wdata(g_wd_p), .raddr(gp[GIW-1:0]), .rdata(gprev_q));
  ffra_ram #(.WIDTH(GLW), .DEPTH(GRANT_SLOTS)) u_gnext (.clk, .we(g_we_n),
    .waddr(g_wa_n), .wdata(g_wd_n), .raddr(gp[GIW-1:0]), .rdata(gnext_q));

  // rounding unit and slot searches
  logic        accept, rnd_start, rnd_done;
  logic [32:0] rnd_len;
  scan_stat_t  gscan_stat, fscan_stat;
  logic [GIW-1:0] gscan_idx;
  logic [FIW-1:0] fscan_idx;
  logic gscan_start, fscan_start;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign rnd_start = accept && (cmd == CMD_ALLOC);

  ffra_round u_round (.clk, .rst, .start(rnd_start),
    .req_length, .done(rnd_done), .len(rnd_len));
  ffra_scan #(.N(GRANT_SLOTS)) u_gscan (.clk, .rst, .start(gscan_start),
    .vec(grant_valid), .stat(gscan_stat), .idx(gscan_idx));
  ffra_scan #(.N(FREE_SLOTS)) u_fscan (.clk, .rst, .start(fscan_start),
    .vec(free_valid), .stat(fscan_stat), .idx(fscan_idx));

  // compare datapath on the extent just read
  logic [32:0] end33, mlen;
  logic fit_top, fit_low, g_match, rel_below, rel_above;
  logic [31:0] new_len;

  assign end33     = {1'b0, fs_q} + {1'b0, fl_q};
  assign mlen      = {1'b0, m_r} + len_r;
  assign fit_top   = (fs_q < m_r) && (mlen < end33);
  assign fit_low   = (m_r <= fs_q) && (len_r[31:0] <= fl_q);
  assign g_match   = (gs_q == addr_r);
  assign rel_below = (({1'b0, gs_r} + {1'b0, gl_r}) == {1'b0, fs_q});
  assign rel_above = (end33 == {1'b0, gs_r});
  assign new_len   = e_len - len_r[31:0];

  assign gscan_start = (state == S_AW_CMP) && (fit_top || fit_low);
  assign fscan_start = (state == S_GW_CMP) && g_match && (cmd_r == CMD_RELEASE);

  // table write ports
  always_comb begin
    f_we_s = 1'b0; f_wa_s = '0; f_wd_s = '0;
    f_we_l = 1'b0; f_wa_l = '0; f_wd_l = '0;
    f_we_p = 1'b0; f_wa_p = '0; f_wd_p = '0;
    f_we_n = 1'b0; f_wa_n = '0; f_wd_n = '0;
    g_we_s = 1'b0; g_wa_s = '0; g_wd_s = '0;
    g_we_l = 1'b0; g_wa_l = '0; g_wd_l = '0;
    g_we_p = 1'b0; g_wa_p = '0; g_wd_p = '0;
    g_we_n = 1'b0; g_wa_n = '0; g_wd_n = '0;
    unique case (state)
      S_INIT: begin
        f_we_s = 1'b1; f_wd_s = cfg_base;
        f_we_l = 1'b1; f_wd_l = cfg_last - cfg_base + 32'd1;
        f_we_p = 1'b1; f_wd_p = FNIL;
        f_we_n = 1'b1; f_wd_n = FNIL;
      end
      S_AG_SCAN: begin
        if (gscan_stat.done && gscan_stat.found) begin
          f_we_l = 1'b1; f_wa_l = fp[FIW-1:0]; f_wd_l = new_len;
          if (!top_r) begin
            f_we_s = 1'b1; f_wa_s = fp[FIW-1:0]; f_wd_s = e_s + len_r[31:0];
            // unlink an emptied extent
            if (new_len == 32'd0) begin
              f_we_n = (e_prev != FNIL); f_wa_n = e_prev[FIW-1:0]; f_wd_n = e_next;
              f_we_p = (e_next != FNIL); f_wa_p = e_next[FIW-1:0]; f_wd_p = e_prev;
            end
          end
        end
      end
      S_GNEW: begin
        g_we_s = 1'b1; g_wa_s = g_slot[GIW-1:0]; g_wd_s = r_addr;
        g_we_l = 1'b1; g_wa_l = g_slot[GIW-1:0]; g_wd_l = len_r[31:0];
        g_we_p = 1'b1; g_wa_p = g_slot[GIW-1:0]; g_wd_p = gtail;
        g_we_n = 1'b1; g_wa_n = g_slot[GIW-1:0]; g_wd_n = GNIL;
      end
      S_GLINK: begin
        g_we_n = 1'b1; g_wa_n = old_gtail[GIW-1:0]; g_wd_n = g_slot;
      end
      S_RF_SCAN: begin
        if (fscan_stat.done && fscan_stat.found) begin
          g_we_n = (g_prev != GNIL); g_wa_n = g_prev[GIW-1:0]; g_wd_n = g_next;
          g_we_p = (g_next != GNIL); g_wa_p = g_next[GIW-1:0]; g_wd_p = g_prev;
        end
      end
      S_RW_CMP: begin
        if (rel_below) begin
          f_we_s = 1'b1; f_wa_s = fp[FIW-1:0]; f_wd_s = gs_r;
        end
        if (rel_below || rel_above) begin
          f_we_l = 1'b1; f_wa_l = fp[FIW-1:0]; f_wd_l = fl_q + gl_r;
        end
      end
      S_RAPP: begin
        f_we_s = 1'b1; f_wa_s = f_slot[FIW-1:0]; f_wd_s = gs_r;
        f_we_l = 1'b1; f_wa_l = f_slot[FIW-1:0]; f_wd_l = gl_r;
        f_we_p = 1'b1; f_wa_p = f_slot[FIW-1:0]; f_wd_p = ftail;
        f_we_n = 1'b1; f_wa_n = f_slot[FIW-1:0]; f_wd_n = FNIL;
      end
      S_FLINK: begin
        f_we_n = 1'b1; f_wa_n = old_ftail[FIW-1:0]; f_wd_n = f_slot;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      cfg_last    <= LAST_ADDR_RESET;
      cfg_base    <= BASE_RESET;
      free_valid  <= '0;
      grant_valid <= '0;
      fhead       <= FNIL;
      ftail       <= FNIL;
      ghead       <= GNIL;
      gtail       <= GNIL;
      used        <= USED_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          free_valid  <= FREE_SLOTS'(1);
          grant_valid <= '0;
          fhead <= '0;
          ftail <= '0;
          ghead <= GNIL;
          gtail <= GNIL;
          used  <= USED_RESET;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r    <= cmd;
            m_r      <= min_start;
            addr_r   <= block_address;
            r_status <= ST_OK;
            r_addr   <= '0;
            r_size   <= '0;
            gp       <= ghead;
            if (cmd == CMD_ALLOC) begin
              state <= S_ROUND;
            end else if (cmd == CMD_RELEASE || cmd == CMD_QUERY) begin
              state <= S_GW_RD;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_ROUND: begin
          if (rnd_done) begin
            len_r <= rnd_len;
            fp    <= ftail;
            if (rnd_len[32]) begin
              r_status <= ST_NO_FIT;
              state    <= S_FINISH;
            end else begin
              state <= S_AW_RD;
            end
          end
        end
        S_AW_RD: begin
          if (fp == FNIL) begin
            r_status <= ST_NO_FIT;
            state    <= S_FINISH;
          end else begin
            state <= S_AW_CMP;
          end
        end
        S_AW_CMP: begin
          e_s    <= fs_q;
          e_len  <= fl_q;
          e_prev <= fprev_q;
          e_next <= fnext_q;
          top_r  <= fit_top;
          if (fit_top || fit_low) begin
            r_addr <= fit_top ? 32'(end33 - len_r) : fs_q;
            state  <= S_AG_SCAN;
          end else begin
            fp    <= fprev_q;
            state <= S_AW_RD;
          end
        end
        S_AG_SCAN: begin
          if (gscan_stat.done) begin
            if (!gscan_stat.found) begin
              r_status <= ST_NO_SLOT;
              r_addr   <= '0;
              state    <= S_FINISH;
            end else begin
              g_slot <= GLW'(gscan_idx);
              if (!top_r && new_len == 32'd0) begin
                free_valid[fp[FIW-1:0]] <= 1'b0;
                if (e_prev == FNIL) fhead <= e_next;
                if (e_next == FNIL) ftail <= e_prev;
              end
              state <= S_GNEW;
            end
          end
        end
        S_GNEW: begin
          grant_valid[g_slot[GIW-1:0]] <= 1'b1;
          used      <= used + USED_W'(len_r[31:0]);
          r_size    <= len_r[31:0];
          old_gtail <= gtail;
          gtail     <= g_slot;
          if (gtail == GNIL) begin
            ghead <= g_slot;
            state <= S_FINISH;
          end else begin
            state <= S_GLINK;
          end
        end
        S_GLINK: begin
          state <= S_FINISH;
        end
        S_GW_RD: begin
          if (gp == GNIL) begin
            r_status <= ST_NOT_FOUND;
            state    <= S_FINISH;
          end else begin
            state <= S_GW_CMP;
          end
        end
        S_GW_CMP: begin
          gs_r   <= gs_q;
          gl_r   <= gl_q;
          g_prev <= gprev_q;
          g_next <= gnext_q;
          if (!g_match) begin
            gp    <= gnext_q;
            state <= S_GW_RD;
          end else if (cmd_r == CMD_QUERY) begin
            r_size <= gl_q;
            state  <= S_FINISH;
          end else begin
            state <= S_RF_SCAN;
          end
        end
        S_RF_SCAN: begin
          if (fscan_stat.done) begin
            if (!fscan_stat.found) begin
              r_status <= ST_NO_SLOT;
              state    <= S_FINISH;
            end else begin
              f_slot <= FLW'(fscan_idx);
              grant_valid[gp[GIW-1:0]] <= 1'b0;
              if (g_prev == GNIL) ghead <= g_next;
              if (g_next == GNIL) gtail <= g_prev;
              used  <= used - USED_W'(gl_r);
              fp    <= fhead;
              state <= S_RW_RD;
            end
          end
        end
        S_RW_RD: begin
          state <= (fp == FNIL) ? S_RAPP : S_RW_CMP;
        end
        S_RW_CMP: begin
          if (rel_below || rel_above) begin
            state <= S_FINISH;
          end else begin
            fp    <= fnext_q;
            state <= S_RW_RD;
          end
        end
        S_RAPP: begin
          free_valid[f_slot[FIW-1:0]] <= 1'b1;
          old_ftail <= ftail;
          ftail     <= f_slot;
          if (ftail == FNIL) begin
            fhead <= f_slot;
            state <= S_FINISH;
          end else begin
            state <= S_FLINK;
          end
        end
        S_FLINK: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hold the result until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= r_status;
            granted_address <= (r_status == ST_OK) ? r_addr : 32'd0;
            block_size      <= (r_status == ST_OK) ? r_size : 32'd0;
            used_total      <= used;
            state           <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
      if (cfg_wr_en) begin
        if (cfg_index == CFG_LAST_ADDR) begin
          cfg_last <= cfg_data;
        end else begin
          cfg_base <= cfg_data;
        end
        state <= S_INIT;
      end
    end
  end

endmodule
`default_nettype wire

/* src/ffra_checker.sv */
// Port-level checks for the region allocator, bound to the top level.
`default_nettype none
module ffra_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [31:0] granted_address,
  input logic [31:0] block_size
);
  import ffra_pkg::*;

  // status and block size of the result hold while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(block_size))
    else $error("result word dropped or changed under stall");

  // one command in flight: stall straight after an accepted word
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while a command is in progress");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> granted_address == 32'd0 && block_size == 32'd0)
    else $error("failed command reports an address or size");

  // table init after reset
  a_init_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during table init");

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (.*);
`default_nettype wire
